[rtl/bdq_pkg.sv]
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared types and codes for the bounded double-ended queue.
// ----------------------------------------------------------------------------
package bdq_pkg;

	typedef logic [1:0] kind_t;
	typedef logic [1:0] status_t;

	localparam kind_t KIND_PUSH_FRONT = 2'd0;
	localparam kind_t KIND_PUSH_BACK  = 2'd1;
	localparam kind_t KIND_POP_FRONT  = 2'd2;
	localparam kind_t KIND_POP_BACK   = 2'd3;

	localparam status_t STATUS_OK    = 2'd0;
	localparam status_t STATUS_EMPTY = 2'd1;
	localparam status_t STATUS_FULL  = 2'd2;

	localparam int WORD_W  = 32;
	localparam int COUNT_W = 5;

	typedef struct packed {
		logic capture;
		logic update;
		logic read;
		logic load;
	} cmd_t;

endpackage

[rtl/bdq_req_if.sv]
// ----------------------------------------------------------------------------
// bdq_req_if
// Request channel: operation kind and data word.
// ----------------------------------------------------------------------------
interface bdq_req_if;
	logic                        valid;
	logic                        ready;
	bdq_pkg::kind_t              kind;
	logic signed [bdq_pkg::WORD_W-1:0] value;

	modport source (output valid, output kind, output value, input ready);
	modport sink   (input valid, input kind, input value, output ready);
endinterface

[rtl/bdq_rsp_if.sv]
// ----------------------------------------------------------------------------
// bdq_rsp_if
// Response channel: front and back words, entry count and status.
// ----------------------------------------------------------------------------
interface bdq_rsp_if;
	logic                               valid;
	logic                               ready;
	logic signed [bdq_pkg::WORD_W-1:0]  front_value;
	logic signed [bdq_pkg::WORD_W-1:0]  back_value;
	logic [bdq_pkg::COUNT_W-1:0]        entry_count;
	bdq_pkg::status_t                   status;

	modport source (output valid, output front_value, output back_value,
		output entry_count, output status, input ready);
	modport sink   (input valid, input front_value, input back_value,
		input entry_count, input status, output ready);
endinterface

[rtl/bdq_ctrl.sv]
// ----------------------------------------------------------------------------
// bdq_ctrl
// Sequencer: accept a request, update state, read the ends, load the result.
// ----------------------------------------------------------------------------
module bdq_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output bdq_pkg::cmd_t cmd
);
	import bdq_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_UPDATE = 4'b0010,
		S_READ   = 4'b0100,
		S_LOAD   = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_UPDATE;
				end
			end
			S_UPDATE: begin
				cmd.update = 1'b1;
				state_d    = S_READ;
			end
			S_READ: begin
				cmd.read = 1'b1;
				state_d  = S_LOAD;
			end
			S_LOAD: begin
				if (slot_free) begin
					cmd.load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[rtl/bdq_dp.sv]
// ----------------------------------------------------------------------------
// bdq_dp
// Ring store, head and count registers, end reads and result register.
// ----------------------------------------------------------------------------
module bdq_dp #(
	parameter int DEPTH = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  bdq_pkg::cmd_t                     cmd,
	input  bdq_pkg::kind_t                    in_kind,
	input  logic signed [bdq_pkg::WORD_W-1:0] in_value,
	output logic signed [bdq_pkg::WORD_W-1:0] front_value,
	output logic signed [bdq_pkg::WORD_W-1:0] back_value,
	output logic [bdq_pkg::COUNT_W-1:0]       entry_count,
	output bdq_pkg::status_t                  status
);
	import bdq_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = CW + 1;

	logic [WORD_W-1:0] mem [DEPTH];

	kind_t              kind_q;
	logic [WORD_W-1:0]  value_q;
	logic [AW-1:0]      head_q, head_d;
	logic [CW-1:0]      count_q, count_d;
	status_t            status_q, status_d;
	logic [WORD_W-1:0]  front_rd_q, back_rd_q;
	logic [WORD_W-1:0]  front_value_q, back_value_q;
	logic [COUNT_W-1:0] entry_count_q;
	status_t            status_out_q;

	logic               full, empty, wr_en;
	logic [AW-1:0]      head_dec, head_inc, tail_addr, back_addr, wr_addr;
	logic [SW-1:0]      tail_sum, back_sum;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);

	assign head_dec = (head_q == '0) ? AW'(DEPTH - 1) : head_q - AW'(1);
	assign head_inc = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);

	assign tail_sum  = SW'(head_q) + SW'(count_q);
	assign tail_addr = (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH)) : AW'(tail_sum);

	assign back_sum  = SW'(head_q) + SW'(count_q) - SW'(1);
	assign back_addr = empty ? head_q :
		((back_sum >= SW'(DEPTH)) ? AW'(back_sum - SW'(DEPTH)) : AW'(back_sum));

	always_comb begin
		head_d   = head_q;
		count_d  = count_q;
		status_d = STATUS_OK;
		wr_en    = 1'b0;
		wr_addr  = tail_addr;
		unique case (kind_q)
			KIND_PUSH_FRONT: begin
				if (full) begin
					status_d = STATUS_FULL;
				end else begin
					head_d  = head_dec;
					count_d = count_q + CW'(1);
					wr_en   = 1'b1;
					wr_addr = head_dec;
				end
			end
			KIND_PUSH_BACK: begin
				if (full) begin
					status_d = STATUS_FULL;
				end else begin
					count_d = count_q + CW'(1);
					wr_en   = 1'b1;
				end
			end
			KIND_POP_FRONT: begin
				if (empty) begin
					status_d = STATUS_EMPTY;
				end else begin
					head_d  = head_inc;
					count_d = count_q - CW'(1);
				end
			end
			KIND_POP_BACK: begin
				if (empty) begin
					status_d = STATUS_EMPTY;
				end else begin
					count_d = count_q - CW'(1);
				end
			end
			default: status_d = STATUS_OK;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else if (cmd.update) begin
			head_q  <= head_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q  <= in_kind;
			value_q <= in_value;
		end
		if (cmd.update) begin
			status_q <= status_d;
		end
		if (cmd.load) begin
			front_value_q <= empty ? '0 : front_rd_q;
			back_value_q  <= empty ? '0 : back_rd_q;
			entry_count_q <= COUNT_W'(count_q);
			status_out_q  <= status_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update && wr_en) begin
			mem[wr_addr] <= value_q;
		end
		if (cmd.read) begin
			front_rd_q <= mem[head_q];
			back_rd_q  <= mem[back_addr];
		end
	end

	assign front_value = front_value_q;
	assign back_value  = back_value_q;
	assign entry_count = entry_count_q;
	assign status      = status_out_q;

endmodule

[rtl/bounded_deque.sv]
// ----------------------------------------------------------------------------
// bounded_deque
// Double-ended queue of signed 32-bit words with fixed capacity in a ring.
//
//   channel  dir  payload                                       request
//   req      in   kind, value                                   one operation
//   rsp      out  front_value, back_value, entry_count, status  one result
//
// Each request goes through four steps: accept, update head/count and write the
// ring, read both ends on the two read ports, load the result register.
// The result register holds a response while the next request is accepted;
// a stalled rsp holds the sequencer in its load step.
// Reset clears head, count and valid; ring contents need no clearing.
// ----------------------------------------------------------------------------
module bounded_deque #(
	parameter int DEPTH = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	bdq_req_if.sink    req,
	bdq_rsp_if.source  rsp
);
	import bdq_pkg::*;

	cmd_t cmd;

	bdq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd)
	);

	bdq_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.in_kind     (req.kind),
		.in_value    (req.value),
		.front_value (rsp.front_value),
		.back_value  (rsp.back_value),
		.entry_count (rsp.entry_count),
		.status      (rsp.status)
	);

endmodule
